// File: sv/glosw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glosw_pkg
// Shared types, constants and helpers for the grid line-of-sight walker.
// ----------------------------------------------------------------------------
package glosw_pkg;

    // Grid geometry. Coordinates on the ports are always five bits wide.
    localparam int GRID_SIDE = 32;
    localparam int COORD_W   = 5;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W    = $clog2(CELLS);

    // Error term and remaining-cell counter widths.
    localparam int ERR_W     = COORD_W + 3;
    localparam int REM_W     = COORD_W + 1;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    // Input beat.
    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               cell_blocked;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
    } t_glosw_in;

    // Output beat.
    typedef struct packed {
        logic [COORD_W-1:0] step_x;
        logic [COORD_W-1:0] step_y;
        logic               last_step;
        logic               hit_wall;
        logic               target_seen;
    } t_glosw_out;

    // Classified job handed from the front to the back.
    typedef struct packed {
        logic                    is_cast;
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic                    blocked;
        logic [COORD_W-1:0]      tx;
        logic [COORD_W-1:0]      ty;
        logic [COORD_W-1:0]      dx;
        logic [COORD_W-1:0]      dy;
        logic                    x_up;
        logic                    y_up;
        logic signed [ERR_W-1:0] err;
        logic [REM_W-1:0]        rem;
    } t_glosw_job;

    // Walker states.
    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_glosw_state;

    // True when a cell lies inside the grid.
    function automatic logic cell_in_grid(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y);
        cell_in_grid = ({1'b0, x} < (COORD_W+1)'(GRID_SIDE)) &&
                       ({1'b0, y} < (COORD_W+1)'(GRID_SIDE));
    endfunction

    // Row-major bitmap address of a cell.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y);
        cell_addr = ADDR_W'(ADDR_W'(y) * ADDR_W'(GRID_SIDE) + ADDR_W'(x));
    endfunction

endpackage
`default_nettype wire

// File: sv/glosw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glosw_front
// Accepts input beats and classifies them into jobs for the walker queue.
// ----------------------------------------------------------------------------
module glosw_front import glosw_pkg::*; (
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_glosw_in  i_in_data,
    input  wire logic       i_queue_full,
    input  wire logic       i_clearing,
    output logic            o_push,
    output t_glosw_job      o_job
);

    logic               x_up;
    logic               y_up;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;

    // Take a beat whenever the queue has room and the bitmap is usable.
    assign o_in_ready = !i_queue_full && !i_clearing;
    assign o_push     = i_in_valid && o_in_ready;

    // Direction and distance along each axis.
    always_comb begin
        x_up = i_in_data.target_x > i_in_data.cell_x;
        y_up = i_in_data.target_y > i_in_data.cell_y;
        dx   = x_up ? i_in_data.target_x - i_in_data.cell_x
                    : i_in_data.cell_x - i_in_data.target_x;
        dy   = y_up ? i_in_data.target_y - i_in_data.cell_y
                    : i_in_data.cell_y - i_in_data.target_y;
    end

    // Build the job with its initial error term and cell count.
    always_comb begin
        o_job.is_cast = (i_in_data.command == CMD_CAST);
        o_job.x       = i_in_data.cell_x;
        o_job.y       = i_in_data.cell_y;
        o_job.blocked = i_in_data.cell_blocked;
        o_job.tx      = i_in_data.target_x;
        o_job.ty      = i_in_data.target_y;
        o_job.dx      = dx;
        o_job.dy      = dy;
        o_job.x_up    = x_up;
        o_job.y_up    = y_up;
        o_job.err     = $signed(ERR_W'(dx)) - $signed(ERR_W'(dy));
        o_job.rem     = REM_W'(1) + REM_W'(dx) + REM_W'(dy);
    end

endmodule
`default_nettype wire

// File: sv/glosw_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glosw_fifo
// Short job queue that decouples the front from the walker.
// ----------------------------------------------------------------------------
module glosw_fifo import glosw_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_glosw_job i_job,
    input  wire logic       i_pop,
    output logic            o_full,
    output logic            o_not_empty,
    output t_glosw_job      o_job
);

    t_glosw_job        r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    // Status flags.
    assign o_full      = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/glosw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glosw_back
// Holds the blocked-cell bitmap, applies writes and walks cast rays.
// ----------------------------------------------------------------------------
module glosw_back import glosw_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_job_valid,
    input  wire t_glosw_job i_job,
    output logic            o_pop,
    output logic            o_clearing,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_glosw_out      o_out_data
);

    t_glosw_state            r_state;
    t_glosw_state            n_state;

    logic                    r_bitmap [CELLS];
    logic                    r_rd_bit;
    logic                    r_rd_in;
    logic                    r_clearing;
    logic [ADDR_W-1:0]       r_clr_addr;

    logic [COORD_W-1:0]      r_x;
    logic [COORD_W-1:0]      n_x;
    logic [COORD_W-1:0]      r_y;
    logic [COORD_W-1:0]      n_y;
    logic [COORD_W-1:0]      r_tx;
    logic [COORD_W-1:0]      n_tx;
    logic [COORD_W-1:0]      r_ty;
    logic [COORD_W-1:0]      n_ty;
    logic [COORD_W-1:0]      r_dx;
    logic [COORD_W-1:0]      n_dx;
    logic [COORD_W-1:0]      r_dy;
    logic [COORD_W-1:0]      n_dy;
    logic                    r_x_up;
    logic                    n_x_up;
    logic                    r_y_up;
    logic                    n_y_up;
    logic signed [ERR_W-1:0] r_err;
    logic signed [ERR_W-1:0] n_err;
    logic [REM_W-1:0]        r_rem;
    logic [REM_W-1:0]        n_rem;

    logic                    r_out_valid;
    t_glosw_out              r_out;

    logic                    slot_free;
    logic                    wall;
    logic                    last;
    logic                    start_cast;
    logic                    do_write;
    logic                    emit;
    logic                    advance;

    // The current cell is a wall only if it lies in the grid.
    assign slot_free = !r_out_valid || i_out_ready;
    assign wall      = r_rd_bit && r_rd_in;
    assign last      = wall || (r_rem == REM_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid && !r_clearing && i_job.is_cast) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (slot_free && last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the walker.
    always_comb begin
        o_pop      = 1'b0;
        start_cast = 1'b0;
        do_write   = 1'b0;
        emit       = 1'b0;
        advance    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop      = i_job_valid && !r_clearing;
                start_cast = o_pop && i_job.is_cast;
                do_write   = o_pop && !i_job.is_cast && cell_in_grid(i_job.x, i_job.y);
            end
            ST_WALK: begin
                emit    = slot_free;
                advance = slot_free && !last;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // Ray position, error term and cell count.
    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_tx   = r_tx;
        n_ty   = r_ty;
        n_dx   = r_dx;
        n_dy   = r_dy;
        n_x_up = r_x_up;
        n_y_up = r_y_up;
        n_err  = r_err;
        n_rem  = r_rem;
        if (start_cast) begin
            n_x    = i_job.x;
            n_y    = i_job.y;
            n_tx   = i_job.tx;
            n_ty   = i_job.ty;
            n_dx   = i_job.dx;
            n_dy   = i_job.dy;
            n_x_up = i_job.x_up;
            n_y_up = i_job.y_up;
            n_err  = i_job.err;
            n_rem  = i_job.rem;
        end else if (advance) begin
            n_rem = r_rem - REM_W'(1);
            if (r_err > 0) begin
                n_x   = r_x_up ? r_x + COORD_W'(1) : r_x - COORD_W'(1);
                n_err = r_err - $signed({2'b00, r_dy, 1'b0});
            end else begin
                n_y   = r_y_up ? r_y + COORD_W'(1) : r_y - COORD_W'(1);
                n_err = r_err + $signed({2'b00, r_dx, 1'b0});
            end
        end
    end

    // Walker registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_tx   <= n_tx;
        r_ty   <= n_ty;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_x_up <= n_x_up;
        r_y_up <= n_y_up;
        r_err  <= n_err;
        r_rem  <= n_rem;
    end

    // Bitmap: clearing pass, cell writes, and a registered read of the next cell.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_bitmap[r_clr_addr] <= 1'b0;
        end else if (do_write) begin
            r_bitmap[cell_addr(i_job.x, i_job.y)] <= i_job.blocked;
        end
        r_rd_bit <= r_bitmap[cell_addr(n_x, n_y)];
        r_rd_in  <= cell_in_grid(n_x, n_y);
    end

    // Clearing pass sequencer, one cell per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (emit) begin
            r_out.step_x      <= r_x;
            r_out.step_y      <= r_y;
            r_out.last_step   <= last;
            r_out.hit_wall    <= wall;
            r_out.target_seen <= last && (r_x == r_tx) && (r_y == r_ty);
        end
    end

    assign o_clearing  = r_clearing;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// File: sv/grid_line_of_sight_walker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a cast's first cell passes through the queue entry, the walker
// registers and the output register before it appears. A cast holds the
// walker until its last cell is emitted, one bitmap read per cell, longer
// while the receiver stalls; a write command is applied as it is popped.
// Reset: the bitmap is cleared one cell per cycle while o_in_ready stays
// low; the queue and output register start empty.
// ----------------------------------------------------------------------------
// grid_line_of_sight_walker_core
// Keeps a grid of blocked cells and walks 4-connected rays across it.
// ----------------------------------------------------------------------------
module grid_line_of_sight_walker_core import glosw_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_glosw_in i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_glosw_out     o_out_data
);

    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_not_empty;
    logic       clearing;
    t_glosw_job front_job;
    t_glosw_job back_job;

    // Front: takes beats and classifies them.
    glosw_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_queue_full (queue_full),
        .i_clearing   (clearing),
        .o_push       (push),
        .o_job        (front_job)
    );

    // Job queue between the two sides.
    glosw_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (front_job),
        .i_pop       (pop),
        .o_full      (queue_full),
        .o_not_empty (queue_not_empty),
        .o_job       (back_job)
    );

    // Back: bitmap and ray walker.
    glosw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_not_empty),
        .i_job       (back_job),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// File: bench/los_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// los_step_checker
// Watches both channels of the line-of-sight walker. Every accepted input beat
// updates a private copy of the blocked-cell grid or traces the ray across it.
// The traced cells are queued and compared with the output beats in order.
// ----------------------------------------------------------------------------
module los_step_checker import glosw_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire t_glosw_in  i_in_data,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_glosw_out i_out_data,
    output int              o_mismatches,
    output int              o_outstanding
);

    // Private copy of the grid, row-major, one bit per cell.
    bit         wall_map [GRID_SIDE*GRID_SIDE];
    // Cells that the walker still owes, oldest first.
    t_glosw_out owed_steps [$];
    int         mismatches = 0;

    // A cell outside the grid never blocks the ray.
    function automatic bit cell_is_wall(input int col, input int row);
        if (col >= GRID_SIDE || row >= GRID_SIDE)
            return 1'b0;
        return wall_map[cell_addr(COORD_W'(col), COORD_W'(row))];
    endfunction

    // Walk the ray of one cast beat and queue every cell that it visits.
    function automatic void trace_ray(input t_glosw_in beat);
        int         col, row, goal_col, goal_row;
        int         dist_x, dist_y, col_dir, row_dir, err, cells_left;
        bit         wall, final_cell;
        t_glosw_out step;
        col        = beat.cell_x;
        row        = beat.cell_y;
        goal_col   = beat.target_x;
        goal_row   = beat.target_y;
        dist_x     = (goal_col > col) ? goal_col - col : col - goal_col;
        dist_y     = (goal_row > row) ? goal_row - row : row - goal_row;
        col_dir    = (goal_col > col) ? 1 : -1;
        row_dir    = (goal_row > row) ? 1 : -1;
        err        = dist_x - dist_y;
        cells_left = 1 + dist_x + dist_y;
        while (cells_left > 0) begin
            wall               = cell_is_wall(col, row);
            final_cell         = wall || (cells_left == 1);
            step.step_x        = COORD_W'(col);
            step.step_y        = COORD_W'(row);
            step.last_step     = final_cell;
            step.hit_wall      = wall;
            step.target_seen   = final_cell && (col == goal_col) && (row == goal_row);
            owed_steps.insert(owed_steps.size(), step);
            if (final_cell)
                break;
            // A positive error moves along x, otherwise along y.
            if (err > 0) begin
                col = col + col_dir;
                err = err - 2*dist_y;
            end else begin
                row = row + row_dir;
                err = err + 2*dist_x;
            end
            cells_left--;
        end
    endfunction

    // Compare output beats first, then fold in the input beat of this edge.
    always @(posedge i_clk) begin : watch_channels
        t_glosw_out want;
        if (!i_rst_n) begin
            owed_steps.delete();
            foreach (wall_map[i])
                wall_map[i] = 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_steps.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected step beat: x=%0d y=%0d last=%0b wall=%0b seen=%0b",
                                 i_out_data.step_x, i_out_data.step_y,
                                 i_out_data.last_step, i_out_data.hit_wall,
                                 i_out_data.target_seen);
                    mismatches++;
                end else begin
                    want = owed_steps[0];
                    owed_steps.delete(0);
                    if (i_out_data.step_x !== want.step_x ||
                        i_out_data.step_y !== want.step_y ||
                        i_out_data.last_step !== want.last_step ||
                        i_out_data.hit_wall !== want.hit_wall ||
                        i_out_data.target_seen !== want.target_seen) begin
                        if (mismatches < 10) begin
                            $write("step mismatch: expected x=%0d y=%0d last=%0b wall=%0b seen=%0b",
                                   want.step_x, want.step_y, want.last_step,
                                   want.hit_wall, want.target_seen);
                            $display(", got x=%0d y=%0d last=%0b wall=%0b seen=%0b",
                                     i_out_data.step_x, i_out_data.step_y,
                                     i_out_data.last_step, i_out_data.hit_wall,
                                     i_out_data.target_seen);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.command == CMD_CAST)
                    trace_ray(i_in_data);
                else if (i_in_data.cell_x < GRID_SIDE && i_in_data.cell_y < GRID_SIDE)
                    wall_map[cell_addr(i_in_data.cell_x, i_in_data.cell_y)] =
                        i_in_data.cell_blocked;
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= owed_steps.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives grid writes and ray casts into the line-of-sight walker: first a
// directed set of corner cases, then random beats under four idling phases.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import glosw_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BEATS   = 22;
    localparam int SETTLE_CYCLES = 100;

    logic       tb_clk    = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_glosw_in  in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_glosw_out out_data;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;
    int mismatches;
    int steps_owed;

    // 10 ns clock.
    always begin
        #5 tb_clk = 1'b1;
        #5 tb_clk = 1'b0;
    end

    grid_line_of_sight_walker_core dut (
        .i_clk       (tb_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    los_step_checker step_check (
        .i_clk         (tb_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_mismatches  (mismatches),
        .o_outstanding (steps_owed)
    );

    // Receiver stalls at random, as often as the current phase asks.
    always @(posedge tb_clk) begin
        if ($urandom_range(0, 99) < stall_pct)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    // Watchdog: a hung walker or a lost beat ends the run here.
    always @(posedge tb_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_glosw_in make_beat(input logic cmd, input int col, input int row,
                                            input logic blocked, input int goal_col,
                                            input int goal_row);
        t_glosw_in beat;
        beat.command      = cmd;
        beat.cell_x       = COORD_W'(col);
        beat.cell_y       = COORD_W'(row);
        beat.cell_blocked = blocked;
        beat.target_x     = COORD_W'(goal_col);
        beat.target_y     = COORD_W'(goal_row);
        return beat;
    endfunction

    // Half the beats stay in a small corner so that walls there are dense
    // and many rays stop early; the rest span the whole grid.
    function automatic t_glosw_in random_beat();
        t_glosw_in beat;
        int        span;
        span              = ($urandom_range(0, 1) == 1) ? 7 : GRID_SIDE - 1;
        beat.command      = ($urandom_range(0, 99) < 35) ? CMD_WRITE : CMD_CAST;
        beat.cell_x       = COORD_W'($urandom_range(0, span));
        beat.cell_y       = COORD_W'($urandom_range(0, span));
        beat.cell_blocked = ($urandom_range(0, 99) < 70);
        beat.target_x     = COORD_W'($urandom_range(0, span));
        beat.target_y     = COORD_W'($urandom_range(0, span));
        // Now and then a cast that looks at its own start cell.
        if (beat.command == CMD_CAST && $urandom_range(0, 7) == 0) begin
            beat.target_x = beat.cell_x;
            beat.target_y = beat.cell_y;
        end
        return beat;
    endfunction

    // Present one beat and return at the edge where it is accepted. Valid is
    // only dropped when an idle gap is rolled.
    task automatic send_beat(input t_glosw_in beat);
        if ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge tb_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge tb_clk);
        while (!in_ready)
            @(posedge tb_clk);
    endtask

    initial begin
        repeat (10) @(posedge tb_clk);
        rst_n <= 1'b1;

        // Directed corner cases, no idling.
        send_beat(make_beat(CMD_CAST,  0,  0, 1'b0,  0,  0));  // start is the target
        send_beat(make_beat(CMD_WRITE, 0,  0, 1'b1, 31, 31));
        send_beat(make_beat(CMD_CAST,  0,  0, 1'b0,  0,  0));  // blocked start and target
        send_beat(make_beat(CMD_CAST,  0,  0, 1'b1, 31, 31));  // blocked start cell
        send_beat(make_beat(CMD_WRITE, 0,  0, 1'b0,  0,  0));
        send_beat(make_beat(CMD_CAST,  0,  0, 1'b0, 31, 31));  // longest ray
        send_beat(make_beat(CMD_CAST, 31, 31, 1'b1,  0,  0));
        send_beat(make_beat(CMD_CAST, 31,  0, 1'b0,  0, 31));
        send_beat(make_beat(CMD_CAST,  0, 31, 1'b0, 31,  0));
        send_beat(make_beat(CMD_WRITE, 31, 31, 1'b1,  0,  0));
        send_beat(make_beat(CMD_CAST,  0,  0, 1'b0, 31, 31));  // wall on the target
        send_beat(make_beat(CMD_WRITE, 15,  0, 1'b1, 31, 31));
        send_beat(make_beat(CMD_CAST,  0,  0, 1'b0, 31,  0));  // wall mid row
        send_beat(make_beat(CMD_CAST, 31,  0, 1'b0,  0,  0));
        send_beat(make_beat(CMD_CAST,  5, 31, 1'b0,  5,  0));  // straight column
        send_beat(make_beat(CMD_WRITE, 10, 10, 1'b1,  0,  0));
        send_beat(make_beat(CMD_CAST,  0,  0, 1'b0, 20, 20));  // wall on the diagonal
        send_beat(make_beat(CMD_CAST, 20, 20, 1'b1,  0,  0));
        send_beat(make_beat(CMD_WRITE, 31, 31, 1'b0, 31, 31));
        send_beat(make_beat(CMD_WRITE, 15,  0, 1'b0,  0,  0));
        send_beat(make_beat(CMD_WRITE, 10, 10, 1'b0,  0,  0));
        send_beat(make_beat(CMD_CAST,  0,  0, 1'b0, 31, 31));

        // Random beats in four phases of idling.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 63;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 63;
                end
                default: begin
                    idle_pct  = 15;
                    stall_pct = 15;
                end
            endcase
            repeat (PHASE_BEATS)
                send_beat(random_beat());
        end
        in_valid <= 1'b0;

        // Drain the remaining steps, then let the walker settle.
        while (steps_owed != 0)
            @(posedge tb_clk);
        repeat (SETTLE_CYCLES) @(posedge tb_clk);

        if (mismatches == 0 && steps_owed == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
